[sv/spc_pkg.sv]
package spc_pkg;

  // per-flow flag store, slot index is the low bits of flow_slot (power of two depth)
  localparam int unsigned FlowSlots = 1024;
  localparam int unsigned SlotW     = $clog2(FlowSlots);

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgUdpWait   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStunWait  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgVoiceWait = 2'd2;
  localparam logic [CfgDataW-1:0] UdpWaitRst   = 8'd20;
  localparam logic [CfgDataW-1:0] StunWaitRst  = 8'd40;
  localparam logic [CfgDataW-1:0] VoiceWaitRst = 8'd10;

  // payload window used by the signature match
  localparam int unsigned WinBytes = 13;
  localparam int unsigned LitBytes = 9;
  typedef logic [8*WinBytes-1:0] win_t;
  typedef logic [8*LitBytes-1:0] lit_t;

  localparam logic [15:0] TurnHdrLen   = 16'd4;
  localparam logic [15:0] MinSipLen    = 16'd14;
  localparam logic [15:0] VoiceMinLen  = 16'd30;
  localparam logic [15:0] VoiceLenAdj  = 16'd20;
  localparam logic [7:0]  VoiceMarker  = 8'h90;

  typedef enum logic [1:0] {
    VerdictFound   = 2'd0,
    VerdictWait    = 2'd1,
    VerdictExclude = 2'd2
  } verdict_e;

  // literal is right-justified: its first character sits in the top used byte
  function automatic logic lit_eq(input win_t w, input lit_t lit, input int unsigned n);
    logic eq;
    eq = 1'b1;
    for (int unsigned i = 0; i < LitBytes; i++) begin
      if (i < n) begin
        if (w[8*i +: 8] != lit[8*(n-1-i) +: 8]) begin
          eq = 1'b0;
        end
      end
    end
    return eq;
  endfunction

  function automatic logic method_hit(input win_t w, input lit_t up, input lit_t lo,
                                      input int unsigned n);
    win_t tail;
    logic word;
    tail = w >> (8*n);
    word = lit_eq(w, up, n) || lit_eq(w, lo, n);
    return word && (lit_eq(tail, lit_t'("SIP:"), 4) || lit_eq(tail, lit_t'("sip:"), 4));
  endfunction

  function automatic logic sip_hit(input win_t w);
    logic hit;
    hit = method_hit(w, lit_t'("NOTIFY "), lit_t'("notify "), 7)
       || method_hit(w, lit_t'("REGISTER "), lit_t'("register "), 9)
       || method_hit(w, lit_t'("INVITE "), lit_t'("invite "), 7)
       || lit_eq(w, lit_t'("SIP/2.0 "), 8) || lit_eq(w, lit_t'("sip/2.0 "), 8)
       || method_hit(w, lit_t'("BYE "), lit_t'("bye "), 4)
       || method_hit(w, lit_t'("ACK "), lit_t'("ack "), 4)
       || method_hit(w, lit_t'("CANCEL "), lit_t'("cancel "), 7)
       || method_hit(w, lit_t'("OPTIONS "), lit_t'("options "), 8);
    return hit;
  endfunction

endpackage

[sv/spc_if.sv]
interface spc_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  flow_slot;
  logic        flow_start;
  logic [15:0] payload_length;
  logic [63:0] bytes_low;
  logic [63:0] bytes_middle;
  logic [63:0] bytes_high;
  logic        over_udp;
  logic [7:0]  packets_seen;
  logic        flow_is_stun;

  modport source (
    output valid, flow_slot, flow_start, payload_length, bytes_low, bytes_middle,
           bytes_high, over_udp, packets_seen, flow_is_stun,
    input  ready
  );
  modport sink (
    input  valid, flow_slot, flow_start, payload_length, bytes_low, bytes_middle,
           bytes_high, over_udp, packets_seen, flow_is_stun,
    output ready
  );
endinterface

interface spc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       voice_flag;

  modport source (output valid, verdict, voice_flag, input ready);
  modport sink (input valid, verdict, voice_flag, output ready);
endinterface

[sv/sip_packet_classifier_unit.sv]
// channel   | dir | handshake     | payload
// ----------+-----+---------------+------------------------------------------------------
// in_if     | in  | valid/ready   | flow_slot, flow_start, payload_length, bytes_low/
//           |     |               | middle/high, over_udp, packets_seen, flow_is_stun
// out_if    | out | valid/ready   | verdict, voice_flag
// cfg       | in  | cfg_we_i only | cfg_idx_i, cfg_data_i (no read-back)
//
// one item per cycle unless stalled or clearing; two register stages, stage 1 and output
// the flag store is a 1-port-write / 1-port-read ram, read at accept, written back from
// stage 1 as it advances; a one-entry bypass covers an item that follows one of the same flow
// after reset a clearing pass zeroes the flag store, with in ready low while it runs
// a stalled output holds its result; stage 1 then holds too, and in ready drops while it is full
module sip_packet_classifier_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  spc_in_if.sink                         in_if,
  spc_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [spc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [spc_pkg::CfgDataW-1:0]   cfg_data_i
);

  // configuration registers
  logic [spc_pkg::CfgDataW-1:0] udp_wait_q, stun_wait_q, voice_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      udp_wait_q   <= spc_pkg::UdpWaitRst;
      stun_wait_q  <= spc_pkg::StunWaitRst;
      voice_wait_q <= spc_pkg::VoiceWaitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spc_pkg::CfgUdpWait:   udp_wait_q   <= cfg_data_i;
        spc_pkg::CfgStunWait:  stun_wait_q  <= cfg_data_i;
        spc_pkg::CfgVoiceWait: voice_wait_q <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // clearing pass over the flag store
  logic                    clr_busy_q, clr_busy_d;
  logic [spc_pkg::SlotW-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == spc_pkg::SlotW'(spc_pkg::FlowSlots - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // pipeline control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv, s1_fire, in_fire;

  assign s1_adv      = !out_valid_q || out_if.ready;
  assign s1_fire     = s1_valid_q && s1_adv;
  assign in_if.ready = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign in_fire     = in_if.valid && in_if.ready;

  // stage 0: signature match, waiting rules and voice match, from the item and the configuration alone
  logic [191:0]              pay;
  logic [159:0]              wpay;
  logic [15:0]               turn_len, len_w;
  logic                      turn;
  spc_pkg::win_t             win;
  logic                      found, short_zero, wait_early, voice_hit, voice_set;
  logic [spc_pkg::SlotW-1:0] in_slot;

  always_comb begin
    pay      = {in_if.bytes_high, in_if.bytes_middle, in_if.bytes_low};
    // big-endian length at bytes 2..3
    turn_len = {pay[23:16], pay[31:24]};
    turn     = (in_if.payload_length > spc_pkg::TurnHdrLen)
            && ((in_if.payload_length - spc_pkg::TurnHdrLen) == turn_len);
    len_w    = turn ? (in_if.payload_length - spc_pkg::TurnHdrLen) : in_if.payload_length;
    wpay     = turn ? pay[191:32] : pay[159:0];
    win      = wpay[8*spc_pkg::WinBytes-1:0];

    found      = (len_w >= spc_pkg::MinSipLen) && spc_pkg::sip_hit(win);
    // four zero bytes on their own: keepalive
    short_zero = (len_w == spc_pkg::TurnHdrLen) && (win[31:0] == 32'd0);
    wait_early = (in_if.over_udp && (in_if.packets_seen < udp_wait_q))
              || (in_if.over_udp && in_if.flow_is_stun && (in_if.packets_seen < stun_wait_q))
              || short_zero;
    // rtp-like header: marker byte, length byte, zero ssrc/timestamp area
    voice_hit  = (len_w > spc_pkg::VoiceMinLen) && (win[7:0] == spc_pkg::VoiceMarker)
              && ({8'd0, win[31:24]} == (len_w - spc_pkg::VoiceLenAdj))
              && (win[95:32] == 64'd0);
    voice_set  = voice_hit && !found && !wait_early;
    in_slot    = in_if.flow_slot[spc_pkg::SlotW-1:0];
  end

  // stage 1 registers
  logic [spc_pkg::SlotW-1:0] s1_slot_q;
  logic                      s1_start_q, s1_found_q, s1_wait_q, s1_vset_q, s1_vwait_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_slot_q  <= in_slot;
      s1_start_q <= in_if.flow_start;
      s1_found_q <= found;
      s1_wait_q  <= wait_early;
      s1_vset_q  <= voice_set;
      s1_vwait_q <= in_if.packets_seen < voice_wait_q;
    end
  end

  // flag store, registered read at accept, write-back from stage 1
  logic                      mem_q [spc_pkg::FlowSlots];
  logic                      rd_q;
  logic                      mem_we, mem_wdata;
  logic [spc_pkg::SlotW-1:0] mem_waddr;
  logic [spc_pkg::SlotW-1:0] wr_slot_q;
  logic                      wr_flag_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_q <= mem_q[in_slot];
    end
  end

  // last write; newest value of its slot, covers read-during-write
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wr_slot_q <= mem_waddr;
      wr_flag_q <= mem_wdata;
    end
  end

  // stage 1: merge stored flag, decide
  logic              flag_old, flag_new;
  spc_pkg::verdict_e verdict;

  always_comb begin
    flag_old = (wr_slot_q == s1_slot_q) ? wr_flag_q : rd_q;
    flag_new = (!s1_start_q && flag_old) || s1_vset_q;
    priority if (s1_found_q) begin
      verdict = spc_pkg::VerdictFound;
    end else if (s1_wait_q) begin
      verdict = spc_pkg::VerdictWait;
    end else if (flag_new && s1_vwait_q) begin
      verdict = spc_pkg::VerdictWait;
    end else begin
      verdict = spc_pkg::VerdictExclude;
    end
  end

  assign mem_we    = clr_busy_q || s1_fire;
  assign mem_waddr = clr_busy_q ? clr_cnt_q : s1_slot_q;
  assign mem_wdata = clr_busy_q ? 1'b0 : flag_new;

  // output register
  spc_pkg::verdict_e out_verdict_q;
  logic              out_flag_q;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end
    if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_verdict_q <= verdict;
      out_flag_q    <= flag_new;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.verdict    = out_verdict_q;
  assign out_if.voice_flag = out_flag_q;

endmodule

[sv/spc_checker.sv]
module spc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  spc_in_if.sink      in_if,
  spc_out_if.source   out_if
);

  // items accepted and not yet delivered
  logic [1:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> pend_q != 2'd0)
    else $error("result without a pending item");

  a_two_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items in flight");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.verdict == spc_pkg::VerdictFound
                   || out_if.verdict == spc_pkg::VerdictWait
                   || out_if.verdict == spc_pkg::VerdictExclude))
    else $error("verdict code three");

  a_found_no_stall_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.verdict)
                                   && $stable(out_if.voice_flag))
    else $error("stalled result changed");

endmodule

bind sip_packet_classifier_unit spc_checker u_spc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_if  (in_if),
  .out_if (out_if)
);
